// ----- hdl/qam_pkg.sv -----
// qam_pkg: shared widths, codes and types of the packed-bit qam mapper
// no dependencies; imported by every module of the mapper

package qam_pkg;

  // field widths of the channels
  localparam int DATA_W = 8;
  localparam int VB_W   = 4;
  localparam int IDX_W  = 10;
  localparam int SMP_W  = 16;
  localparam int K_W    = 4;

  // bit accumulator: up to nine held bits plus one full byte
  localparam int ACC_W  = 17;
  localparam int CNT_W  = 5;
  localparam int NSYM_W = 4;

  // defaults of the top level parameters
  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam logic [K_W-1:0]    K_RESET   = 4'd2;
  localparam logic [NSYM_W-1:0] MAX_SYMS  = 4'd8;
  localparam logic [VB_W-1:0]   BYTE_BITS = 4'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_K    = 2'd1,
    ST_LEFTOVER = 2'd2
  } status_e;

  typedef enum logic {
    MODE_DATA  = 1'b0,
    MODE_TABLE = 1'b1
  } mode_e;

  // one table lookup (or error beat) handed from the slicer to the read stage
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    status_e          status;
    logic             lob;
  } op_t;

  // bits per symbol values that have a constellation
  function automatic logic k_supported(input logic [K_W-1:0] k);
    logic ok;
    case (k)
      4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- hdl/qam_in_if.sv -----
// qam_in_if: input channel of the mapper, data bytes and table writes
// depends on nothing; payload widths follow the channel definition

interface qam_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [7:0]         data_byte;
  logic [3:0]         valid_bits;
  logic               last_byte;
  logic [9:0]         table_index;
  logic signed [15:0] table_real;
  logic signed [15:0] table_imag;

  modport source (
    output valid, mode, data_byte, valid_bits, last_byte,
           table_index, table_real, table_imag,
    input  ready
  );

  modport sink (
    input  valid, mode, data_byte, valid_bits, last_byte,
           table_index, table_real, table_imag,
    output ready
  );
endinterface

// ----- hdl/qam_out_if.sv -----
// qam_out_if: result channel of the mapper, one mapped point or error per beat
// depends on nothing; payload widths follow the channel definition

interface qam_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sym_real;
  logic signed [15:0] sym_imag;
  logic [1:0]         status;
  logic               last_of_block;

  modport source (
    output valid, sym_real, sym_imag, status, last_of_block,
    input  ready
  );

  modport sink (
    input  valid, sym_real, sym_imag, status, last_of_block,
    output ready
  );
endinterface

// ----- hdl/qam_tab.sv -----
// qam_tab: constellation memory, one write port and one registered read port
// uses qam_pkg; contents undefined until written

module qam_tab
  import qam_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int SW    = SAMPLE_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [2*SW-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [2*SW-1:0] rdata_o
);

  logic [2*SW-1:0] mem [DEPTH];
  logic [2*SW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/qam_slicer.sv -----
// qam_slicer: bit accumulator that cuts the byte stream into k-bit indices
// uses qam_pkg; issues one lookup or error beat per cycle to the read stage while op_ready_i is high

module qam_slicer
  import qam_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [K_W-1:0]    k_i,
  input  logic              load_i,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic [VB_W-1:0]   valid_bits_i,
  input  logic              last_byte_i,
  output logic              ready_o,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output op_t               op_o
);

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [CNT_W-1:0]  cnt;
    logic [NSYM_W-1:0] nsym;
    logic              act;
    logic              last;
    logic              err;
  } slc_state_t;

  slc_state_t        st_q, st_d, nxt, aft;
  logic [CNT_W-1:0]  k_ext, rem, cnt_new;
  logic              sym_ok, work, issue, aft_work;
  logic [VB_W-1:0]   nv;
  logic [ACC_W-1:0]  idx_mask, acc_new;

  // pending work of the current byte; held bits wait for the next byte
  assign k_ext    = CNT_W'(k_i);
  assign sym_ok   = st_q.act && (st_q.cnt >= k_ext) && (st_q.nsym < MAX_SYMS);
  assign work     = st_q.err | sym_ok | st_q.last;
  assign rem      = st_q.cnt - k_ext;
  assign idx_mask = (ACC_W'(1) << k_i) - ACC_W'(1);

  // next beat and the state it leaves
  always_comb begin
    nxt  = st_q;
    op_o = '{idx: '0, status: ST_OK, lob: 1'b0};
    if (st_q.err) begin
      op_o.status = ST_BAD_K;
      op_o.lob    = st_q.last;
      nxt.err     = 1'b0;
      nxt.last    = 1'b0;
    end else if (sym_ok) begin
      op_o.idx  = IDX_W'((st_q.acc >> rem) & idx_mask);
      op_o.lob  = st_q.last && (rem == '0);
      nxt.cnt   = rem;
      nxt.nsym  = st_q.nsym + NSYM_W'(1);
      if (rem == '0) begin
        nxt.last = 1'b0;
      end
    end else if (st_q.last) begin
      // bits left at block end
      op_o.status = ST_LEFTOVER;
      op_o.lob    = 1'b1;
      nxt.acc     = '0;
      nxt.cnt     = '0;
      nxt.last    = 1'b0;
    end
  end

  assign op_valid_o = work;
  assign issue      = work & op_ready_i;

  // state after this cycle's beat; a new byte may load once nothing is left
  assign aft      = issue ? nxt : st_q;
  assign aft_work = aft.err | aft.last
                    | (aft.act && (aft.cnt >= k_ext) && (aft.nsym < MAX_SYMS));
  assign ready_o  = !aft_work;

  // append the valid leading bits of the new byte
  assign nv      = (valid_bits_i > BYTE_BITS) ? BYTE_BITS : valid_bits_i;
  assign acc_new = (aft.acc << nv) | ACC_W'(data_byte_i >> (BYTE_BITS - nv));
  assign cnt_new = aft.cnt + CNT_W'(nv);

  always_comb begin
    st_d = aft;
    // byte finished: held bits stay idle until the next byte
    if (!aft_work) begin
      st_d.act = 1'b0;
    end
    if (load_i) begin
      if (!k_supported(k_i)) begin
        st_d      = '0;
        st_d.err  = 1'b1;
        st_d.last = last_byte_i;
      end else begin
        st_d.acc  = acc_new;
        st_d.cnt  = cnt_new;
        st_d.nsym = '0;
        st_d.act  = 1'b1;
        st_d.err  = 1'b0;
        st_d.last = last_byte_i && (cnt_new != '0);
        if (last_byte_i && (cnt_new == '0)) begin
          st_d.acc = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ----- hdl/packed_bit_qam_mapper.sv -----
// packed_bit_qam_mapper: top level, register, slicer, constellation memory
// uses qam_pkg, qam_in_if, qam_out_if, qam_slicer and qam_tab
//
//   channel   dir  beat content
//   in_i      in   data byte (mode 0) or constellation entry write (mode 1)
//   out_o     out  one mapped I/Q point, or an error status
//   cfg       in   bits per symbol, written when cfg_we_i is high
//
// A data byte causes n beats (symbols plus a possible error beat); the input
// waits until the last is issued. A table write causes no beat. The single
// read port of the constellation memory gives one beat per cycle unless the
// output stalls. Reset clears the bit accumulator and the pipeline; memory
// contents are undefined until written. Beat attributes sit in an output
// register beside the memory's read register; a stall holds slicer and input.

module packed_bit_qam_mapper
  import qam_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [K_W-1:0] cfg_wdata_i,
  qam_in_if.sink         in_i,
  qam_out_if.source      out_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(TABLE_DEPTH);

  logic [K_W-1:0]            k_q;
  logic                      in_acc, data_load, tab_we, slc_ready;
  logic                      op_valid, adv, rd_en, idx_in_range;
  op_t                       op;
  logic [2*SAMPLE_WIDTH-1:0] tab_wdata, tab_rdata;
  logic signed [SAMPLE_WIDTH-1:0] rd_re, rd_im;
  logic                      s1_v_q, s1_lob_q, s1_zero_q;
  status_e                   s1_status_q;

  // bits per symbol register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  // input beat decode
  assign in_i.ready = slc_ready;
  assign in_acc     = in_i.valid & in_i.ready;
  assign data_load  = in_acc && (in_i.mode == MODE_DATA);
  assign tab_we     = in_acc && (in_i.mode == MODE_TABLE)
                      && ({1'b0, in_i.table_index} < DEPTH_LIM);
  assign tab_wdata  = {SAMPLE_WIDTH'(in_i.table_real), SAMPLE_WIDTH'(in_i.table_imag)};

  qam_slicer u_slicer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .k_i          (k_q),
    .load_i       (data_load),
    .data_byte_i  (in_i.data_byte),
    .valid_bits_i (in_i.valid_bits),
    .last_byte_i  (in_i.last_byte),
    .ready_o      (slc_ready),
    .op_valid_o   (op_valid),
    .op_ready_i   (adv),
    .op_o         (op)
  );

  // read stage moves when the output register is free or being taken
  assign adv          = !s1_v_q || out_o.ready;
  assign rd_en        = op_valid & adv;
  assign idx_in_range = {1'b0, op.idx} < DEPTH_LIM;

  qam_tab #(
    .DEPTH (TABLE_DEPTH),
    .SW    (SAMPLE_WIDTH),
    .AW    (AW)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (in_i.table_index[AW-1:0]),
    .wdata_i (tab_wdata),
    .re_i    (rd_en),
    .raddr_i (op.idx[AW-1:0]),
    .rdata_o (tab_rdata)
  );

  // output register: valid and beat attributes beside the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= op_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_status_q <= op.status;
      s1_lob_q    <= op.lob;
      s1_zero_q   <= (op.status != ST_OK) || !idx_in_range;
    end
  end

  // sign-extend or cut the stored sample to the port width
  assign rd_re = tab_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign rd_im = tab_rdata[SAMPLE_WIDTH-1:0];

  assign out_o.valid         = s1_v_q;
  assign out_o.sym_real      = s1_zero_q ? '0 : SMP_W'(rd_re);
  assign out_o.sym_imag      = s1_zero_q ? '0 : SMP_W'(rd_im);
  assign out_o.status        = s1_status_q;
  assign out_o.last_of_block = s1_lob_q;

  // checks
  a_bad_k_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_load && !k_supported(k_q) |=> op_valid && (op.status == ST_BAD_K))
    else $error("unsupported bits per symbol did not raise an error beat");

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_o.ready |=> $stable(tab_rdata))
    else $error("memory read data changed under a stalled result");

  a_leftover_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == ST_LEFTOVER) |-> out_o.last_of_block)
    else $error("leftover beat without block end mark");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slc_ready |-> op_valid)
    else $error("input held off with no beat pending");

endmodule
